>>> src/psq_pkg.sv
// Shared constants, scale masks and helper functions of the pitch scale quantizer.
package psq_pkg;

    localparam int FRAC_BITS = 16;
    localparam int PITCH_W   = 21;
    localparam int ROOT_W    = 4;
    localparam int CODE_W    = 5;
    localparam int NUM_SEMI  = 13;
    localparam int SEMI_W    = 4;
    localparam int ROOT_N    = 1 << ROOT_W;
    localparam int OFF_W     = FRAC_BITS + 1;
    localparam int DIST_W    = FRAC_BITS + 1;
    localparam int RES_W     = PITCH_W + 2;
    localparam int NUM_GRP   = 4;
    localparam int PIPE_DEPTH = 5;
    localparam int CNT_W     = $clog2(PIPE_DEPTH + 1);

    // Scale codes, in selector order
    localparam logic [CODE_W-1:0] SC_AEOLIAN       = 5'd0;
    localparam logic [CODE_W-1:0] SC_BLUES         = 5'd1;
    localparam logic [CODE_W-1:0] SC_CHROMATIC     = 5'd2;
    localparam logic [CODE_W-1:0] SC_DIATONIC_MIN  = 5'd3;
    localparam logic [CODE_W-1:0] SC_DORIAN        = 5'd4;
    localparam logic [CODE_W-1:0] SC_HARMONIC_MIN  = 5'd5;
    localparam logic [CODE_W-1:0] SC_INDIAN        = 5'd6;
    localparam logic [CODE_W-1:0] SC_LOCRIAN       = 5'd7;
    localparam logic [CODE_W-1:0] SC_LYDIAN        = 5'd8;
    localparam logic [CODE_W-1:0] SC_MAJOR         = 5'd9;
    localparam logic [CODE_W-1:0] SC_MELODIC_MIN   = 5'd10;
    localparam logic [CODE_W-1:0] SC_MINOR         = 5'd11;
    localparam logic [CODE_W-1:0] SC_MIXOLYDIAN    = 5'd12;
    localparam logic [CODE_W-1:0] SC_NATURAL_MIN   = 5'd13;
    localparam logic [CODE_W-1:0] SC_PENTATONIC    = 5'd14;
    localparam logic [CODE_W-1:0] SC_PHRYGIAN      = 5'd15;
    localparam logic [CODE_W-1:0] SC_TURKISH       = 5'd16;
    localparam logic [CODE_W-1:0] SC_NONE_A        = 5'd17;
    localparam logic [CODE_W-1:0] SC_PENTA_MIN     = 5'd18;
    localparam logic [CODE_W-1:0] SC_WHOLE_TONE    = 5'd19;
    localparam logic [CODE_W-1:0] SC_DIMINISHED    = 5'd20;
    localparam logic [CODE_W-1:0] SC_HARMONIC_MAJ  = 5'd21;
    localparam logic [CODE_W-1:0] SC_DOUBLE_HARM   = 5'd22;
    localparam logic [CODE_W-1:0] SC_MAJOR_BEBOP   = 5'd23;
    localparam logic [CODE_W-1:0] SC_MINOR_BEBOP   = 5'd24;
    localparam logic [CODE_W-1:0] SC_PHRYGIAN_DOM  = 5'd25;
    localparam logic [CODE_W-1:0] SC_HUNGARIAN_MIN = 5'd26;
    localparam logic [CODE_W-1:0] SC_ALTERED       = 5'd27;
    localparam logic [CODE_W-1:0] SC_NONE_B        = 5'd28;

    localparam logic [NUM_SEMI-1:0] MASK_NONE      = '0;
    localparam logic [NUM_SEMI-1:0] MASK_CHROMATIC = '1;

    typedef logic [ROOT_N-1:0][OFF_W-1:0] off_arr_t;

    // One candidate degree: present in the scale, semitone index, distance to the fraction
    typedef struct packed {
        logic              ok;
        logic [SEMI_W-1:0] idx;
        logic [DIST_W-1:0] gap;
    } cand_t;

    // n / 12 volt in fixed point, rounded to nearest
    function automatic off_arr_t twelfths();
        off_arr_t t;
        for (int i = 0; i < ROOT_N; i++) begin
            t[i] = OFF_W'(((longint'(i) << FRAC_BITS) + 64'sd6) / 12);
        end
        return t;
    endfunction

    localparam off_arr_t TWELFTH = twelfths();

    // Bit k set: semitone k belongs to the scale; zero marks a none code
    function automatic logic [NUM_SEMI-1:0] scale_mask(input logic [CODE_W-1:0] code);
        logic [NUM_SEMI-1:0] m;
        unique case (code)
            SC_AEOLIAN:       m = 13'b1_0101_1010_1101;
            SC_BLUES:         m = 13'b1_0100_1110_1001;
            SC_CHROMATIC:     m = 13'b1_1111_1111_1111;
            SC_DIATONIC_MIN:  m = 13'b1_0101_1010_1101;
            SC_DORIAN:        m = 13'b1_0110_1010_1101;
            SC_HARMONIC_MIN:  m = 13'b1_1001_1010_1101;
            SC_INDIAN:        m = 13'b1_0101_0011_0011;
            SC_LOCRIAN:       m = 13'b1_0101_0110_1011;
            SC_LYDIAN:        m = 13'b1_1010_1101_0101;
            SC_MAJOR:         m = 13'b1_1010_1011_0101;
            SC_MELODIC_MIN:   m = 13'b1_1111_1010_1101;
            SC_MINOR:         m = 13'b1_0101_1010_1101;
            SC_MIXOLYDIAN:    m = 13'b1_0110_1011_0101;
            SC_NATURAL_MIN:   m = 13'b1_0101_1010_1101;
            SC_PENTATONIC:    m = 13'b1_0010_1001_0101;
            SC_PHRYGIAN:      m = 13'b1_0101_1010_1011;
            SC_TURKISH:       m = 13'b1_1100_1010_1011;
            SC_NONE_A:        m = MASK_NONE;
            SC_PENTA_MIN:     m = 13'b1_0100_1010_1001;
            SC_WHOLE_TONE:    m = 13'b1_0101_0101_0101;
            SC_DIMINISHED:    m = 13'b1_1011_0110_1101;
            SC_HARMONIC_MAJ:  m = 13'b1_1001_1011_0101;
            SC_DOUBLE_HARM:   m = 13'b1_1001_1011_0011;
            SC_MAJOR_BEBOP:   m = 13'b1_1011_1011_0101;
            SC_MINOR_BEBOP:   m = 13'b1_0111_1010_1101;
            SC_PHRYGIAN_DOM:  m = 13'b1_0101_1011_0011;
            SC_HUNGARIAN_MIN: m = 13'b1_1001_1100_1101;
            SC_ALTERED:       m = 13'b1_0101_0101_1011;
            SC_NONE_B:        m = MASK_NONE;
            default:          m = MASK_NONE;
        endcase
        return m;
    endfunction

    // a holds the lower semitone: b wins only when a is not in the scale or b is strictly closer
    function automatic cand_t pick(input cand_t a, input cand_t b);
        cand_t r;
        if (b.ok && (!a.ok || (b.gap < a.gap))) begin
            r = b;
        end else begin
            r = a;
        end
        return r;
    endfunction

endpackage

>>> src/pitch_scale_quantizer_core.sv
// Top level of the pitch scale quantizer: five-stage pipeline from pitch word to quantized pitch.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------------
//  s_       | s_valid / s_ready     | s_pitch_in, s_root_note, s_scale_select
//  m_       | m_valid / m_ready     | m_pitch_out
//  cfg_     | cfg_valid / cfg_ready | cfg_wdata (none_is_chromatic)
//
//  One word enters per cycle while m_ready does not stall the pipeline; each word
//  passes through the five register stages (root subtract, distances, two halves of the
//  nearest-degree tree, final add with saturation).
//  Each stage advances when it is empty or the stage after it advances, so a
//  stall on m_ready freezes only the filled stages and bubbles still close up.
//  Reset (aresetn low, synchronous) clears all stage valid bits and the
//  configuration bit; cfg_ready is always high.
module pitch_scale_quantizer_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [psq_pkg::PITCH_W-1:0]  s_pitch_in,
    input  logic [psq_pkg::ROOT_W-1:0]          s_root_note,
    input  logic [psq_pkg::CODE_W-1:0]          s_scale_select,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [psq_pkg::PITCH_W-1:0]  m_pitch_out,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_wdata
);
    import psq_pkg::*;

    localparam logic signed [RES_W-1:0] RES_MAX = RES_W'((64'sd1 <<< (PITCH_W - 1)) - 64'sd1);
    localparam logic signed [RES_W-1:0] RES_MIN = RES_W'(-(64'sd1 <<< (PITCH_W - 1)));

    // Configuration register
    logic chrom_reg;

    // Stage valid bits and advance enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic adv1, adv2, adv3, adv4, adv5;

    // Stage 1: fraction relative to root, scale mask
    logic signed [PITCH_W-1:0]  pitch1_reg;
    logic [FRAC_BITS-1:0]       frac1_reg,  frac1_next;
    logic [NUM_SEMI-1:0]        mask1_reg,  mask1_next;
    logic                       pass1_reg,  pass1_next;
    logic [NUM_SEMI-1:0]        mask_raw;
    logic [OFF_W-1:0]           root_off;

    // Stage 2: distances
    logic signed [PITCH_W-1:0]  pitch2_reg;
    logic [FRAC_BITS-1:0]       frac2_reg;
    logic [NUM_SEMI-1:0]        mask2_reg;
    logic                       pass2_reg;
    logic [DIST_W-1:0]          dist2 [NUM_SEMI];

    // Stage 3: best candidate of each group of four, and semitone 12 on its own
    logic signed [PITCH_W-1:0]  pitch3_reg;
    logic [FRAC_BITS-1:0]       frac3_reg;
    logic                       pass3_reg;
    cand_t                      cand [NUM_SEMI];
    cand_t                      grp3_reg  [NUM_GRP];
    cand_t                      grp3_next [NUM_GRP];

    // Stage 4: chosen semitone
    logic signed [PITCH_W-1:0]  pitch4_reg;
    logic [FRAC_BITS-1:0]       frac4_reg;
    logic                       pass4_reg;
    logic [SEMI_W-1:0]          idx4_reg;
    cand_t                      best4;

    // Stage 5: output word
    logic signed [PITCH_W-1:0]  out5_reg, out5_next;
    logic signed [RES_W-1:0]    res5;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chrom_reg <= 1'b0;
        end else if (cfg_valid) begin
            chrom_reg <= cfg_wdata;
        end
    end

    // A stage takes a new word when it is empty or its word moves on
    assign adv5    = !v5_reg || m_ready;
    assign adv4    = !v4_reg || adv5;
    assign adv3    = !v3_reg || adv4;
    assign adv2    = !v2_reg || adv3;
    assign adv1    = !v1_reg || adv2;
    assign s_ready = adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (adv1) begin
                v1_reg <= s_valid;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
            if (adv3) begin
                v3_reg <= v2_reg;
            end
            if (adv4) begin
                v4_reg <= v3_reg;
            end
            if (adv5) begin
                v5_reg <= v4_reg;
            end
        end
    end

    // Stage 1: only the fraction bits of pitch - root offset matter downstream
    assign mask_raw = scale_mask(s_scale_select);
    assign root_off = TWELFTH[s_root_note];

    always_comb begin
        frac1_next = s_pitch_in[FRAC_BITS-1:0] - root_off[FRAC_BITS-1:0];
        if (mask_raw == MASK_NONE) begin
            mask1_next = chrom_reg ? MASK_CHROMATIC : MASK_NONE;
            pass1_next = !chrom_reg;
        end else begin
            mask1_next = mask_raw;
            pass1_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            pitch1_reg <= s_pitch_in;
            frac1_reg  <= frac1_next;
            mask1_reg  <= mask1_next;
            pass1_reg  <= pass1_next;
        end
    end

    // Stage 2: distance to each semitone offset
    psq_dist u_dist (
        .aclk  (aclk),
        .en    (adv2),
        .frac  (frac1_reg),
        .dists (dist2)
    );

    always_ff @(posedge aclk) begin
        if (adv2) begin
            pitch2_reg <= pitch1_reg;
            frac2_reg  <= frac1_reg;
            mask2_reg  <= mask1_reg;
            pass2_reg  <= pass1_reg;
        end
    end

    // Stage 3: first half of the tree; lower semitone always on the left to keep ties
    always_comb begin
        for (int k = 0; k < NUM_SEMI; k++) begin
            cand[k].ok  = mask2_reg[k];
            cand[k].idx = SEMI_W'(k);
            cand[k].gap = dist2[k];
        end
        grp3_next[0] = pick(pick(cand[0], cand[1]), pick(cand[2], cand[3]));
        grp3_next[1] = pick(pick(cand[4], cand[5]), pick(cand[6], cand[7]));
        grp3_next[2] = pick(pick(cand[8], cand[9]), pick(cand[10], cand[11]));
        grp3_next[3] = cand[12];
    end

    always_ff @(posedge aclk) begin
        if (adv3) begin
            pitch3_reg <= pitch2_reg;
            frac3_reg  <= frac2_reg;
            pass3_reg  <= pass2_reg;
            grp3_reg   <= grp3_next;
        end
    end

    // Stage 4: second half of the tree
    assign best4 = pick(pick(grp3_reg[0], grp3_reg[1]), pick(grp3_reg[2], grp3_reg[3]));

    always_ff @(posedge aclk) begin
        if (adv4) begin
            pitch4_reg <= pitch3_reg;
            frac4_reg  <= frac3_reg;
            pass4_reg  <= pass3_reg;
            idx4_reg   <= best4.idx;
        end
    end

    // Stage 5: pitch - fraction + degree offset, saturated to the pitch range; pass-through words keep their pitch
    assign res5 = RES_W'(pitch4_reg)
                - $signed({{(RES_W - FRAC_BITS){1'b0}}, frac4_reg})
                + $signed({{(RES_W - OFF_W){1'b0}}, TWELFTH[idx4_reg]});

    always_comb begin
        if (pass4_reg) begin
            out5_next = pitch4_reg;
        end else if (res5 > RES_MAX) begin
            out5_next = RES_MAX[PITCH_W-1:0];
        end else if (res5 < RES_MIN) begin
            out5_next = RES_MIN[PITCH_W-1:0];
        end else begin
            out5_next = res5[PITCH_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv5) begin
            out5_reg <= out5_next;
        end
    end

    assign m_valid     = v5_reg;
    assign m_pitch_out = out5_reg;

endmodule

>>> src/psq_dist.sv
// Distance stage: registers the distance of the fraction to every semitone offset.
module psq_dist (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [psq_pkg::FRAC_BITS-1:0] frac,
    output logic [psq_pkg::DIST_W-1:0] dists [psq_pkg::NUM_SEMI]
);
    import psq_pkg::*;

    logic [DIST_W-1:0] dist_reg  [NUM_SEMI];
    logic [DIST_W-1:0] dist_next [NUM_SEMI];
    logic [DIST_W-1:0] frac_ext;

    assign frac_ext = {1'b0, frac};

    always_comb begin
        for (int k = 0; k < NUM_SEMI; k++) begin
            if (frac_ext >= TWELFTH[k]) begin
                dist_next[k] = frac_ext - TWELFTH[k];
            end else begin
                dist_next[k] = TWELFTH[k] - frac_ext;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dist_reg <= dist_next;
        end
    end

    assign dists = dist_reg;

endmodule

>>> src/psq_checker.sv
// Port-level checker for the pitch scale quantizer, bound to the top level.
module psq_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [psq_pkg::PITCH_W-1:0]  m_pitch_out
);
    import psq_pkg::*;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             take_in, take_out;

    assign take_in  = s_valid && s_ready;
    assign take_out = m_valid && m_ready;

    // Track words in flight
    always_comb begin
        cnt_next = cnt_reg;
        if (take_in && !take_out) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (take_out && !take_in) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pitch_out))
        else $error("stalled result dropped or changed");

    a_drain_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output drains");

    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(PIPE_DEPTH))
        else $error("more words in flight than pipeline stages");

    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == '0 |-> !m_valid)
        else $error("result shown with no word in flight");

endmodule

bind pitch_scale_quantizer_core psq_checker u_psq_checker (.*);

>>> verif/tb_pitch_scale_quantizer_core.sv
// Self-checking testbench for the pitch scale quantizer core.
`timescale 1ns / 1ps

module tb_pitch_scale_quantizer_core;

    import psq_pkg::*;

    // Generous ceiling: 1057 words, each with random stalls on either side
    localparam int CYCLE_LIMIT = 200_000;

    // Degree list of one scale: len entries, deg[0] first, semitones 0..12
    typedef struct packed {
        logic [3:0]        len;
        logic [0:12][3:0]  deg;
    } scale_degrees_t;

    // One accepted input word and the pitch it must come back as
    typedef struct {
        logic [PITCH_W-1:0] pitch;
        logic [ROOT_W-1:0]  root;
        logic [CODE_W-1:0]  code;
        logic [PITCH_W-1:0] quantized;
    } pending_note_t;

    logic                       aclk           = 1'b0;
    logic                       aresetn        = 1'b0;
    logic                       s_valid        = 1'b0;
    logic                       s_ready;
    logic signed [PITCH_W-1:0]  s_pitch_in     = '0;
    logic [ROOT_W-1:0]          s_root_note    = '0;
    logic [CODE_W-1:0]          s_scale_select = '0;
    logic                       m_valid;
    logic                       m_ready        = 1'b0;
    logic signed [PITCH_W-1:0]  m_pitch_out;
    logic                       cfg_valid      = 1'b0;
    logic                       cfg_ready;
    logic                       cfg_wdata      = 1'b0;

    // Testbench copy of the configuration register
    bit            none_chromatic = 1'b0;
    pending_note_t pending_notes[$];
    int            mismatch_count = 0;
    int            cycle_count    = 0;
    int            src_idle_pct   = 31;
    int            sink_idle_pct  = 55;

    pitch_scale_quantizer_core u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pitch_in     (s_pitch_in),
        .s_root_note    (s_root_note),
        .s_scale_select (s_scale_select),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pitch_out    (m_pitch_out),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_wdata      (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Degrees written as one hex digit per semitone, in table order.
    // A length of zero marks a none code (17, 28 and the unused 29..31).
    function automatic scale_degrees_t scale_degrees(logic [CODE_W-1:0] code);
        scale_degrees_t s;
        unique case (code)
            SC_AEOLIAN:       s = {4'd8,  52'h023578AC00000};
            SC_BLUES:         s = {4'd7,  52'h03567AC000000};
            SC_CHROMATIC:     s = {4'd13, 52'h0123456789ABC};
            SC_DIATONIC_MIN:  s = {4'd8,  52'h023578AC00000};
            SC_DORIAN:        s = {4'd8,  52'h023579AC00000};
            SC_HARMONIC_MIN:  s = {4'd8,  52'h023578BC00000};
            SC_INDIAN:        s = {4'd8,  52'h011458AC00000};
            SC_LOCRIAN:       s = {4'd8,  52'h013568AC00000};
            SC_LYDIAN:        s = {4'd8,  52'h024679BC00000};
            SC_MAJOR:         s = {4'd8,  52'h024579BC00000};
            SC_MELODIC_MIN:   s = {4'd10, 52'h0235789ABC000};
            SC_MINOR:         s = {4'd8,  52'h023578AC00000};
            SC_MIXOLYDIAN:    s = {4'd8,  52'h024579AC00000};
            SC_NATURAL_MIN:   s = {4'd8,  52'h023578AC00000};
            SC_PENTATONIC:    s = {4'd6,  52'h02479C0000000};
            SC_PHRYGIAN:      s = {4'd8,  52'h013578AC00000};
            SC_TURKISH:       s = {4'd8,  52'h01357ABC00000};
            SC_PENTA_MIN:     s = {4'd6,  52'h0357AC0000000};
            SC_WHOLE_TONE:    s = {4'd7,  52'h02468AC000000};
            SC_DIMINISHED:    s = {4'd9,  52'h0235689BC0000};
            SC_HARMONIC_MAJ:  s = {4'd8,  52'h024578BC00000};
            SC_DOUBLE_HARM:   s = {4'd8,  52'h014578BC00000};
            SC_MAJOR_BEBOP:   s = {4'd9,  52'h0245789BC0000};
            SC_MINOR_BEBOP:   s = {4'd9,  52'h0235789AC0000};
            SC_PHRYGIAN_DOM:  s = {4'd8,  52'h014578AC00000};
            SC_HUNGARIAN_MIN: s = {4'd8,  52'h023678BC00000};
            SC_ALTERED:       s = {4'd8,  52'h013468AC00000};
            default:          s = '0;
        endcase
        return s;
    endfunction

    // n semitones as volts, rounded to nearest
    function automatic longint semitone_volts(int unsigned n);
        return ((longint'(n) << FRAC_BITS) + 6) / 12;
    endfunction

    function automatic logic [PITCH_W-1:0] quantize_pitch(logic [PITCH_W-1:0] raw,
                                                          logic [ROOT_W-1:0] root,
                                                          logic [CODE_W-1:0] code,
                                                          bit chromatic);
        scale_degrees_t sc;
        longint         pitch, frac, nearest, nearest_dist, cand, gap, res;
        longint         hi, lo;
        int             i;
        sc = scale_degrees(code);
        if (sc.len == 0) begin
            if (!chromatic) begin
                return raw;
            end
            sc = scale_degrees(SC_CHROMATIC);
        end
        pitch = longint'($signed(raw));
        // fraction of the octave above the root, always in [0, 1) V
        frac = (pitch - semitone_volts(root)) & ((longint'(1) << FRAC_BITS) - 1);
        nearest = semitone_volts(sc.deg[0]);
        nearest_dist = (frac > nearest) ? frac - nearest : nearest - frac;
        // strict compare: on a tie the earlier degree keeps the spot
        for (i = 1; i < sc.len; i++) begin
            cand = semitone_volts(sc.deg[i]);
            gap = (frac > cand) ? frac - cand : cand - frac;
            if (gap < nearest_dist) begin
                nearest_dist = gap;
                nearest = cand;
            end
        end
        res = pitch - frac + nearest;
        hi = (longint'(1) << (PITCH_W - 1)) - 1;
        lo = -(longint'(1) << (PITCH_W - 1));
        if (res > hi) begin
            res = hi;
        end
        if (res < lo) begin
            res = lo;
        end
        return PITCH_W'(res);
    endfunction

    // ------------------------------------------------------------------
    // Shared driving and checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string msg);
        mismatch_count++;
        // keep the log bounded when the block is badly broken
        if (mismatch_count <= 100) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
    endtask

    // Send one word: idle first at the sender's rate, then hold valid and payload
    // until the block takes the word, and log what must come back.
    task automatic send_note(logic [PITCH_W-1:0] pitch, logic [ROOT_W-1:0] root,
                             logic [CODE_W-1:0] code);
        pending_note_t n;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_pitch_in     <= pitch;
        s_root_note    <= root;
        s_scale_select <= code;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        n.pitch     = pitch;
        n.root      = root;
        n.code      = code;
        n.quantized = quantize_pitch(pitch, root, code, none_chromatic);
        pending_notes.push_back(n);
    endtask

    // Drop valid and let the pipeline empty out before anything else happens
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_notes.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Only called with the pipeline empty; the model copy flips on acceptance
    task automatic set_chromatic(bit mode);
        cfg_valid <= 1'b1;
        cfg_wdata <= mode;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        none_chromatic = mode;
        cfg_valid <= 1'b0;
    endtask

    // Random word, biased toward the interesting spots of the octave
    task automatic send_random_note();
        logic [ROOT_W-1:0] root;
        logic [CODE_W-1:0] code;
        longint            pitch;
        int                sel;
        sel  = $urandom_range(99);
        root = ($urandom_range(99) < 80) ? ROOT_W'($urandom_range(11)) : ROOT_W'($urandom);
        code = CODE_W'($urandom);
        if (sel < 65) begin
            // declared range, about +/-10 V
            pitch = longint'($urandom_range(1310719)) - 655360;
        end else if (sel < 85) begin
            // just around the midpoint of two degrees above the root: tie handling
            pitch = (longint'($urandom_range(19)) - 10) * (longint'(1) << FRAC_BITS)
                  + semitone_volts(root)
                  + (semitone_volts($urandom_range(12)) + semitone_volts($urandom_range(12))) / 2
                  + longint'($urandom_range(2)) - 1;
        end else begin
            // whole 21-bit space, including the saturating corners
            pitch = longint'($urandom);
        end
        send_note(PITCH_W'(pitch), root, code);
    endtask

    // Compare each word taken from the block with the oldest expectation
    always @(posedge aclk) begin : result_check
        pending_note_t n;
        if (aresetn && m_valid && m_ready) begin
            if (pending_notes.size() == 0) begin
                report_mismatch($sformatf("unexpected word pitch_out=%0d",
                                          $signed(m_pitch_out)));
            end else begin
                n = pending_notes.pop_front();
                if (m_pitch_out !== n.quantized) begin
                    report_mismatch($sformatf(
                        "pitch_out=%0d want %0d (pitch_in=%0d root=%0d scale=%0d chrom=%0b)",
                        $signed(m_pitch_out), $signed(n.quantized), $signed(n.pitch),
                        n.root, n.code, none_chromatic));
                end
            end
        end
    end

    // Receiver back-pressure at the current rate
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Watchdog: a hung handshake or a lost word ends here
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // One word per scale code with the register at its reset value; edge cases
    // ride along on chosen codes.
    task automatic test_scale_sweep();
        logic [PITCH_W-1:0] pitch;
        logic [ROOT_W-1:0]  root;
        int                 c;
        for (c = 0; c < 32; c++) begin
            pitch = PITCH_W'(longint'($urandom_range(1310719)) - 655360);
            root  = ROOT_W'($urandom_range(11));
            unique case (CODE_W'(c))
                // top of the word: nearest degree is the next octave, clamp high
                SC_AEOLIAN:       begin pitch = 21'h0FFFFF; root = 0; end
                SC_BLUES:         begin pitch = -21'sd655360; root = 0; end
                SC_CHROMATIC:     begin pitch = 21'sd655359; root = 11; end
                // bottom of the word, rounding down past it: clamp low
                SC_MAJOR:         begin pitch = 21'h100000; root = 2; end
                // roots beyond B used as given
                SC_MIXOLYDIAN:    root = 12;
                SC_NATURAL_MIN:   root = 13;
                SC_PENTATONIC:    root = 14;
                SC_PHRYGIAN:      root = 15;
                // exactly halfway between degrees 2 and 4: the earlier one wins
                SC_MAJOR_BEBOP:   begin pitch = 21'sd212992; root = 0; end
                SC_NONE_A:        begin pitch = -21'sd655360; root = 15; end
                SC_NONE_B:        pitch = 21'sd655359;
                default: begin
                    // unused codes pass through like none
                    if (CODE_W'(c) > SC_NONE_B) begin
                        pitch = PITCH_W'($urandom);
                        root  = ROOT_W'($urandom);
                    end
                end
            endcase
            send_note(pitch, root, CODE_W'(c));
        end
        wait_drained();
    endtask

    // None codes with chromatic mode on, corners of the word included
    task automatic test_none_chromatic();
        set_chromatic(1'b1);
        send_note(21'h0FFFFF, 4'd0, SC_NONE_A);
        send_note(21'h100000, 4'd1, SC_NONE_B);
        send_note(PITCH_W'($urandom), ROOT_W'($urandom_range(11)), CODE_W'(29));
        send_note(PITCH_W'($urandom), 4'd15, CODE_W'(30));
        send_note(-21'sd1, ROOT_W'($urandom), CODE_W'(31));
        wait_drained();
        set_chromatic(1'b0);
    endtask

    // Random traffic at one idling profile and one register setting
    task automatic test_random_traffic(int n_notes, int src_pct, int sink_pct, bit mode);
        int i;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        set_chromatic(mode);
        for (i = 0; i < n_notes; i++) begin
            send_random_note();
        end
        wait_drained();
    endtask

    initial begin
        // hold reset at the start, then release it for good
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_scale_sweep();
        test_none_chromatic();

        // sender idle about a third of the time, receiver stalled over half; then swapped; then flat out
        test_random_traffic(170, 31, 55, 1'b0);
        test_random_traffic(170, 31, 55, 1'b1);
        test_random_traffic(170, 55, 31, 1'b0);
        test_random_traffic(170, 55, 31, 1'b1);
        test_random_traffic(170, 0, 0, 1'b1);
        test_random_traffic(170, 0, 0, 1'b0);

        // catch any stray word beyond the pipeline depth
        repeat (4 * PIPE_DEPTH) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
